[rtl/core/stl_pkg.sv]
// shared types and constants for the symbol table lookup block
// used by stl_ctrl, stl_dp and symbol_table_lookup; depends on nothing
`default_nettype none

package stl_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 4096;
	localparam int NAME_BYTES  = 8;
	localparam int NAME_W      = NAME_BYTES * 8;
	localparam int TYPE_W      = 8;
	localparam int VALUE_W     = 32;
	localparam int INDEX_W     = 12;

	// stream payload widths
	localparam int S_DATA_W = 216;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 56;
	localparam int M_USER_W = 2;

	// reset value of the type mask register
	localparam logic [TYPE_W-1:0] TYPE_MASK_RST = 8'd30;

	// command codes carried in s_tuser
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_ADDR   = 2'd2,
		OP_NAME   = 2'd3
	} stl_op_t;

	// result status codes carried in m_tuser
	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_MISS = 2'd1,
		STS_FULL = 2'd2
	} stl_status_t;

	// one stored table entry
	typedef struct packed {
		logic [NAME_W-1:0]  name;
		logic [TYPE_W-1:0]  typ;
		logic [VALUE_W-1:0] value;
	} stl_entry_t;

	// controller state
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} stl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic emit;
	} stl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic count_zero;
		logic scan_last;
		logic out_free;
	} stl_stat_t;

endpackage

`default_nettype wire

[rtl/core/stl_ctrl.sv]
// controller state machine for the symbol table lookup block
// depends on stl_pkg; drives stl_dp through stl_cmd_t, reads stl_stat_t
`default_nettype none

module stl_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [1:0]                 in_op,
	output logic                            in_ready,
	input  wire stl_pkg::stl_stat_t         stat,
	output stl_pkg::stl_cmd_t               cmd
);

	stl_pkg::stl_state_t state_q;
	stl_pkg::stl_state_t state_nxt;
	stl_pkg::stl_op_t    op;

	assign op = stl_pkg::stl_op_t'(in_op);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stl_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			stl_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (op) inside
						stl_pkg::OP_ADDR, stl_pkg::OP_NAME: begin
							state_nxt = stat.count_zero ? stl_pkg::ST_RESULT
							                            : stl_pkg::ST_SCAN;
						end
						default: begin
							state_nxt = stl_pkg::ST_EXEC;
						end
					endcase
				end
			end
			stl_pkg::ST_EXEC: begin
				state_nxt = stl_pkg::ST_RESULT;
			end
			stl_pkg::ST_SCAN: begin
				if (stat.scan_last) begin
					state_nxt = stl_pkg::ST_DRAIN;
				end
			end
			stl_pkg::ST_DRAIN: begin
				state_nxt = stl_pkg::ST_RESULT;
			end
			stl_pkg::ST_RESULT: begin
				if (stat.out_free) begin
					state_nxt = stl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = stl_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			stl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			stl_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			stl_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			stl_pkg::ST_DRAIN: begin
				cmd = '0;
			end
			stl_pkg::ST_RESULT: begin
				cmd.emit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/stl_dp.sv]
// datapath for the symbol table lookup block: entry memory, scan compare,
// best-match registers and the output word register; depends on stl_pkg
`default_nettype none

module stl_dp #(
	parameter int TABLE_DEPTH = stl_pkg::TABLE_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wen,
	input  wire logic [stl_pkg::TYPE_W-1:0]      cfg_wdata,
	input  wire logic [stl_pkg::S_DATA_W-1:0]    in_data,
	input  wire logic [stl_pkg::S_USER_W-1:0]    in_user,
	input  wire stl_pkg::stl_cmd_t               cmd,
	output stl_pkg::stl_stat_t                   stat,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [stl_pkg::M_DATA_W-1:0]         out_data,
	output logic [stl_pkg::M_USER_W-1:0]         out_user
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int NW    = stl_pkg::NAME_W;
	localparam int TW    = stl_pkg::TYPE_W;
	localparam int VW    = stl_pkg::VALUE_W;
	localparam int XW    = stl_pkg::INDEX_W;
	localparam logic [7:0] PREFIX_CHAR = 8'h5F;

	// c-string compare over the fixed name width, stops at the first nul
	function automatic logic name_eq(input logic [NW-1:0] a, input logic [NW-1:0] b);
		logic eq;
		logic ended;
		eq    = 1'b1;
		ended = 1'b0;
		for (int i = 0; i < stl_pkg::NAME_BYTES; i++) begin
			if (!ended && (a[8*i +: 8] != b[8*i +: 8])) begin
				eq = 1'b0;
			end
			if (a[8*i +: 8] == 8'h00) begin
				ended = 1'b1;
			end
		end
		return eq;
	endfunction

	// entry memory
	stl_pkg::stl_entry_t mem [TABLE_DEPTH];

	logic [TW-1:0]        type_mask_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     ptr_q;
	stl_pkg::stl_op_t     op_q;
	stl_pkg::stl_entry_t  new_entry_q;
	logic [VW-1:0]        limit_q;
	logic [TW-1:0]        type_a_q;
	logic [TW-1:0]        type_b_q;
	logic [NW-1:0]        qname_q;
	stl_pkg::stl_status_t exec_sts_q;

	// read pipeline stage
	stl_pkg::stl_entry_t  rd_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 vld_s1;

	// primary hit (address floor or exact name) and prefixed-name hit
	logic                 hit_a_q;
	logic [IDX_W-1:0]     idx_a_q;
	logic [VW-1:0]        val_a_q;
	logic [TW-1:0]        typ_a_q;
	logic                 hit_b_q;
	logic [IDX_W-1:0]     idx_b_q;
	logic [VW-1:0]        val_b_q;
	logic [TW-1:0]        typ_b_q;

	logic                 out_valid_q;
	logic [stl_pkg::M_DATA_W-1:0] out_data_q;
	logic [stl_pkg::M_USER_W-1:0] out_user_q;

	logic                 full;
	logic [TW-1:0]        rd_mtype;
	logic                 addr_hit;
	logic                 name_hit;
	logic                 alt_hit;
	logic [NW-1:0]        alt_name;

	stl_pkg::stl_status_t res_sts;
	logic [IDX_W-1:0]     res_idx;
	logic [VW-1:0]        res_val;
	logic [TW-1:0]        res_typ;

	assign full     = (count_q == CNT_W'(TABLE_DEPTH));
	assign alt_name = {qname_q[NW-9:0], PREFIX_CHAR};

	// type mask register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_mask_q <= stl_pkg::TYPE_MASK_RST;
		end else if (cfg_wen) begin
			type_mask_q <= cfg_wdata;
		end
	end

	// latch the accepted word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q              <= stl_pkg::stl_op_t'(in_user[1:0]);
			new_entry_q.name  <= in_data[63:0];
			new_entry_q.typ   <= in_data[71:64];
			new_entry_q.value <= in_data[103:72];
			limit_q           <= {1'b0, in_data[134:104]};
			type_a_q          <= in_data[143:136];
			type_b_q          <= in_data[151:144];
			qname_q           <= in_data[215:152];
		end
	end

	// entry count, clear and append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (op_q == stl_pkg::OP_CLEAR) begin
				count_q <= '0;
			end else if (!full) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (op_q == stl_pkg::OP_APPEND && full) begin
				exec_sts_q <= stl_pkg::STS_FULL;
			end else begin
				exec_sts_q <= stl_pkg::STS_OK;
			end
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == stl_pkg::OP_APPEND && !full) begin
			mem[count_q[IDX_W-1:0]] <= new_entry_q;
		end
		if (cmd.scan) begin
			rd_s1 <= mem[ptr_q];
		end
		idx_s1 <= ptr_q;
	end

	// scan pointer and read valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan;
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.scan) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
		end
	end

	// compare the entry read back
	assign rd_mtype = rd_s1.typ & type_mask_q;
	assign addr_hit = vld_s1 && (op_q == stl_pkg::OP_ADDR)
	               && (rd_mtype == type_a_q || rd_mtype == type_b_q)
	               && (rd_s1.value <= limit_q) && (rd_s1.value > val_a_q);
	assign name_hit = vld_s1 && (op_q == stl_pkg::OP_NAME) && !hit_a_q
	               && name_eq(rd_s1.name, qname_q);
	assign alt_hit  = vld_s1 && (op_q == stl_pkg::OP_NAME) && !hit_b_q
	               && name_eq(rd_s1.name, alt_name);

	// best and first match registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
		end else if (cmd.load) begin
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
		end else begin
			if (addr_hit || name_hit) begin
				hit_a_q <= 1'b1;
			end
			if (alt_hit) begin
				hit_b_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_a_q <= '0;
		end else if (addr_hit || name_hit) begin
			val_a_q <= rd_s1.value;
			idx_a_q <= idx_s1;
			typ_a_q <= rd_s1.typ;
		end
		if (alt_hit) begin
			val_b_q <= rd_s1.value;
			idx_b_q <= idx_s1;
			typ_b_q <= rd_s1.typ;
		end
	end

	// result selection
	always_comb begin
		res_sts = stl_pkg::STS_MISS;
		res_idx = '0;
		res_val = '0;
		res_typ = '0;
		case (op_q) inside
			stl_pkg::OP_CLEAR, stl_pkg::OP_APPEND: begin
				res_sts = exec_sts_q;
			end
			stl_pkg::OP_ADDR: begin
				if (hit_a_q) begin
					res_sts = stl_pkg::STS_OK;
					res_idx = idx_a_q;
					res_val = val_a_q;
					res_typ = typ_a_q;
				end
			end
			default: begin
				if (hit_a_q) begin
					res_sts = stl_pkg::STS_OK;
					res_idx = idx_a_q;
					res_val = val_a_q;
					res_typ = typ_a_q;
				end else if (hit_b_q) begin
					res_sts = stl_pkg::STS_OK;
					res_idx = idx_b_q;
					res_val = val_b_q;
					res_typ = typ_b_q;
				end
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_user_q <= res_sts;
			out_data_q <= {4'b0, res_typ, res_val, XW'(res_idx)};
		end
	end

	// status to controller
	assign stat.count_zero = (count_q == '0);
	assign stat.scan_last  = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

`default_nettype wire

[rtl/core/symbol_table_lookup.sv]
// Symbol table lookup, top level.
// Slave stream (s_*) takes one command word: s_tuser is the command (clear,
// append, address lookup, name lookup), s_tdata the append entry and the
// query fields. Master stream (m_*) returns exactly one result word per
// command: m_tuser is the status (ok, not found, table full), m_tdata the
// matching index, value and raw type, all zero when nothing matched.
// cfg_wen/cfg_wdata write the 8-bit type mask applied before type compares.
// Clear and append pass from accept through an execute state to the result.
// A lookup walks the loaded entries one per cycle through the single read
// port of the entry memory (entry count up to 4096 at default depth), then
// a drain state; an empty table skips the scan. One command is in
// work at a time; the next is accepted once the result sits in the output
// register. Reset empties the table (entry count to zero, no memory sweep)
// and sets the type mask to 30. When m_tready is low the result holds in
// the output register and the block stalls before loading the next result.
// Depends on stl_pkg, stl_ctrl and stl_dp.
`default_nettype none

module symbol_table_lookup #(
	parameter int TABLE_DEPTH = stl_pkg::TABLE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// type mask register write
	input  wire logic                          cfg_wen,
	input  wire logic [stl_pkg::TYPE_W-1:0]    cfg_wdata,
	// command words
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// entry_name, entry_type, entry_value, query_addr, type_a, type_b, query_name
	input  wire logic [stl_pkg::S_DATA_W-1:0]  s_tdata,
	// cmd
	input  wire logic [stl_pkg::S_USER_W-1:0]  s_tuser,
	// result words
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// match_index, match_value, match_type, zero pad
	output logic [stl_pkg::M_DATA_W-1:0]       m_tdata,
	// status
	output logic [stl_pkg::M_USER_W-1:0]       m_tuser
);

	stl_pkg::stl_cmd_t  cmd;
	stl_pkg::stl_stat_t stat;

	// sequencer
	stl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser[1:0]),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table memory and compare
	stl_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule

`default_nettype wire
